### src/lfu_cache_lru_tiebreak_macros.svh
// Assertion macros for the LFU cache block.
// Used by the top level only; needs clk and rst_n in the including scope.
`ifndef LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
`ifndef SYNTH
`define LFU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LFU_ASSERT_SAME(lbl, ante, cons, msg)
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### src/lfu_pkg.sv
// Shared types and constants of the LFU cache block.
// No dependencies; used by the controller, the datapath, the top level and the testbench.
package lfu_pkg;

  localparam int DEF_CAPACITY    = 16;
  localparam int DEF_COUNT_WIDTH = 16;
  localparam int CFG_WIDTH       = 5;
  localparam logic [CFG_WIDTH-1:0] CFG_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_TAIL   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_HIT    = 8'b0001_0000,
    S_EVICT  = 8'b0010_0000,
    S_INSERT = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } lfu_state_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic hit_upd;
    logic evict;
    logic insert;
    logic out_load;
  } lfu_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic is_put;
    logic limit_zero;
    logic need_evict;
  } lfu_sts_t;

endpackage

### src/lfu_cache_lru_tiebreak.sv
// Top level of the LFU cache with least-recently-used tie break.
// Depends on lfu_pkg, lfu_ctrl, lfu_dp and the assertion macro header.
//
// Usage: items arrive on the in_ stream (tuser = operation, tdata = key and
// value); every item yields exactly one result item on the out_ stream.
// A get hit returns the stored value and counts as a use; while the limit is
// nonzero, a put updates a present key or inserts a new one, evicting the
// entry with the lowest use count (the least recently touched among equals)
// once the fill reaches the limit. The cfg_ port writes the capacity limit; it
// is always ready. The user must write it only while the block is idle; the
// block itself does not enforce this.
// A get miss or an ignored put goes from the decision straight to the result;
// a hit passes through the update state, an insert through the insert state,
// and an eviction through the evict and insert states. Most of the time is
// spent in the scan, which reads one entry per cycle from the entry memories
// to find the key match, the fill and the eviction victim.
// One item is worked on at a time. A finished result waits in the output
// register while the next item is already scanned; if the receiver stalls,
// the block holds in its final state until the output register frees up.
// Reset clears all valid bits (the cache is empty), sets the limit to 16
// and drops any pending result.
module lfu_cache_lru_tiebreak #(
  parameter int CAPACITY    = lfu_pkg::DEF_CAPACITY,
  parameter int COUNT_WIDTH = lfu_pkg::DEF_COUNT_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [63:0]                   in_tdata,   // key [31:0], value [63:32]
  input  logic                          in_tuser,   // cmd [0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // hit [0], read_value [32:1],
                                                    // evicted [33], zeros [39:34]
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lfu_pkg::CFG_WIDTH-1:0] cfg_data
);
  import lfu_pkg::*;

  `include "lfu_cache_lru_tiebreak_macros.svh"

  lfu_cmd_t             cmd;
  lfu_sts_t             sts;
  logic [CFG_WIDTH-1:0] cap_limit_r;
  logic                 res_hit, res_evicted;
  logic [31:0]          res_read_value;

  // The limit register is always ready for a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_limit_r <= CFG_RESET;
    end else if (cfg_valid) begin
      cap_limit_r <= cfg_data;
    end
  end

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfu_dp #(
    .CAPACITY    (CAPACITY),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cap_limit      (cap_limit_r),
    .op_cmd         (in_tuser),
    .op_key         (in_tdata[31:0]),
    .op_value       (in_tdata[63:32]),
    .res_hit        (res_hit),
    .res_read_value (res_read_value),
    .res_evicted    (res_evicted)
  );

  assign out_tdata = {6'd0, res_evicted, res_read_value, res_hit};

  // An accepted item keeps the input closed while it is being worked on.
  `LFU_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "input open after accept")
  // A put that hits never evicts.
  `LFU_ASSERT_SAME(a_no_hit_evict, out_tvalid, !(out_tdata[0] && out_tdata[33]), "hit and evict")
  // Only a hit can return a nonzero value.
  `LFU_ASSERT_SAME(a_value_needs_hit, out_tvalid && out_tdata[32:1] != 32'd0, out_tdata[0], "value without hit")

endmodule

### src/lfu_ctrl.sv
// Controller of the LFU cache: sequences scan, update and result hand-off.
// Depends on lfu_pkg for the state and command/status types.
module lfu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lfu_pkg::lfu_sts_t sts,
  output lfu_pkg::lfu_cmd_t cmd
);
  import lfu_pkg::*;

  lfu_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_last) state_nxt = S_TAIL;
      end
      S_TAIL: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (sts.found) begin
          state_nxt = (sts.is_put && sts.limit_zero) ? S_DONE : S_HIT;
        end else if (sts.is_put && !sts.limit_zero) begin
          state_nxt = sts.need_evict ? S_EVICT : S_INSERT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_HIT: begin
        cmd.hit_upd = 1'b1;
        state_nxt   = S_DONE;
      end
      S_EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/lfu_dp.sv
// Datapath of the LFU cache: entry memories, rank and valid flops, scan tracking.
// Depends on lfu_pkg for the command/status types and codes.
module lfu_dp #(
  parameter int CAPACITY    = lfu_pkg::DEF_CAPACITY,
  parameter int COUNT_WIDTH = lfu_pkg::DEF_COUNT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lfu_pkg::lfu_cmd_t              cmd,
  output lfu_pkg::lfu_sts_t              sts,
  input  logic [lfu_pkg::CFG_WIDTH-1:0]  cap_limit,
  input  logic                           op_cmd,
  input  logic [31:0]                    op_key,
  input  logic [31:0]                    op_value,
  output logic                           res_hit,
  output logic [31:0]                    res_read_value,
  output logic                           res_evicted
);
  import lfu_pkg::*;

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILLW = $clog2(CAPACITY + 1);
  localparam int LIMW = (FILLW > CFG_WIDTH) ? FILLW : CFG_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  logic [31:0]            key_mem [CAPACITY];
  logic [31:0]            data_mem[CAPACITY];
  logic [COUNT_WIDTH-1:0] cnt_mem [CAPACITY];
  logic [CAPACITY-1:0]    valid_r;
  logic [IDXW-1:0]        rank_r  [CAPACITY];

  logic                   op_cmd_r;
  logic [31:0]            op_key_r, op_val_r;
  logic [IDXW-1:0]        idx_r, ridx_r;
  logic                   rd_vld_r;
  logic [31:0]            key_q, data_q;
  logic [COUNT_WIDTH-1:0] cnt_q;

  logic                   found_r, free_found_r, vic_found_r, evicted_r;
  logic [IDXW-1:0]        s_r, free_r, vic_r;
  logic [31:0]            s_data_r;
  logic [COUNT_WIDTH-1:0] s_cnt_r, vic_cnt_r;
  logic [IDXW-1:0]        vic_rank_r;
  logic [FILLW-1:0]       fill_r;

  logic                   res_hit_r, res_ev_r;
  logic [31:0]            res_rd_r;

  logic                   cur_vld, better;
  logic [IDXW-1:0]        cur_rank, slot, s_rank;
  logic [LIMW-1:0]        limit;

  assign cur_vld  = rd_vld_r & valid_r[ridx_r];
  assign cur_rank = rank_r[ridx_r];
  assign better   = !vic_found_r || (cnt_q < vic_cnt_r) ||
                    ((cnt_q == vic_cnt_r) && (cur_rank > vic_rank_r));
  assign slot     = evicted_r ? vic_r : free_r;
  assign s_rank   = rank_r[s_r];
  assign limit    = (LIMW'(cap_limit) > LIMW'(CAPACITY)) ? LIMW'(CAPACITY)
                                                          : LIMW'(cap_limit);

  assign sts.scan_last  = (idx_r == IDXW'(CAPACITY - 1));
  assign sts.found      = found_r;
  assign sts.is_put     = (op_cmd_r == CMD_PUT);
  assign sts.limit_zero = (limit == '0);
  assign sts.need_evict = (LIMW'(fill_r) >= limit);

  assign res_hit        = res_hit_r;
  assign res_read_value = res_rd_r;
  assign res_evicted    = res_ev_r;

  // Entry memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      key_q  <= key_mem[idx_r];
      data_q <= data_mem[idx_r];
      cnt_q  <= cnt_mem[idx_r];
    end
    if (cmd.hit_upd) begin
      cnt_mem[s_r] <= (s_cnt_r == CNT_MAX) ? s_cnt_r : s_cnt_r + CNT_ONE;
      if (op_cmd_r == CMD_PUT) data_mem[s_r] <= op_val_r;
    end
    if (cmd.insert) begin
      key_mem[slot]  <= op_key_r;
      data_mem[slot] <= op_val_r;
      cnt_mem[slot]  <= CNT_ONE;
    end
  end

  // Per-entry valid bits and recency ranks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.evict) valid_r[vic_r] <= 1'b0;
      if (cmd.insert) valid_r[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.hit_upd) begin
        if (IDXW'(i) == s_r) rank_r[i] <= '0;
        else if (valid_r[i] && rank_r[i] < s_rank) rank_r[i] <= rank_r[i] + 1'b1;
      end else if (cmd.evict) begin
        if (valid_r[i] && rank_r[i] > vic_rank_r) rank_r[i] <= rank_r[i] - 1'b1;
      end else if (cmd.insert) begin
        if (IDXW'(i) == slot) rank_r[i] <= '0;
        else if (valid_r[i]) rank_r[i] <= rank_r[i] + 1'b1;
      end
    end
  end

  // Scan control and tracking of match, fill, free slot and victim.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      rd_vld_r <= cmd.scan_en;
      if (cmd.load) idx_r <= '0;
      else if (cmd.scan_en) idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= idx_r;
    if (cmd.load) begin
      op_cmd_r     <= op_cmd;
      op_key_r     <= op_key;
      op_val_r     <= op_value;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      vic_found_r  <= 1'b0;
      evicted_r    <= 1'b0;
      fill_r       <= '0;
    end else begin
      if (cur_vld) begin
        fill_r <= fill_r + 1'b1;
        if (!found_r && key_q == op_key_r) begin
          found_r  <= 1'b1;
          s_r      <= ridx_r;
          s_data_r <= data_q;
          s_cnt_r  <= cnt_q;
        end
        if (better) begin
          vic_found_r <= 1'b1;
          vic_r       <= ridx_r;
          vic_cnt_r   <= cnt_q;
          vic_rank_r  <= cur_rank;
        end
      end else if (rd_vld_r && !free_found_r) begin
        free_found_r <= 1'b1;
        free_r       <= ridx_r;
      end
      if (cmd.evict) evicted_r <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_hit_r <= found_r;
      res_ev_r  <= evicted_r;
      res_rd_r  <= (found_r && op_cmd_r == CMD_GET) ? s_data_r : 32'd0;
    end
  end

endmodule

### test/lfu_cache_lru_tiebreak_tb.sv
// Self-checking testbench for the LFU cache with least-recently-used tie break.
// Depends on lfu_pkg and the lfu_cache_lru_tiebreak top level; a predictor
// inside this file computes the expected result of every accepted item.
`timescale 1ns / 100ps

module lfu_cache_lru_tiebreak_tb;
  import lfu_pkg::*;

  localparam int NSLOT     = DEF_CAPACITY;
  localparam int CNT_MAX   = (1 << DEF_COUNT_WIDTH) - 1;
  localparam int WDOG_MAX  = 4000;
  localparam int N_RANDOM  = 1800;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_WIDTH-1:0] cfg_data;

  lfu_cache_lru_tiebreak DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // One operation and one result, in the block's field widths.
  typedef struct packed {
    logic        cmd;
    logic [31:0] key;
    logic [31:0] value;
  } cache_op_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
  } cache_resp_t;

  // Predictor state: a private copy of the cache contents.
  logic        slot_used [NSLOT];
  logic [31:0] slot_key  [NSLOT];
  logic [31:0] slot_data [NSLOT];
  int          slot_uses [NSLOT];
  int          slot_age  [NSLOT];
  int          cur_limit;

  cache_resp_t resp_fifo[$];
  int          n_fail;
  int          n_mismatch;
  int          wdog;

  // Idling percentages for the sender and receiver; changed per phase.
  int          send_idle_pct;
  int          recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int find_slot(logic [31:0] k);
    for (int i = 0; i < NSLOT; i++)
      if (slot_used[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  // Move one slot to the front of the recency order.
  function automatic void make_newest(int s);
    int r;
    r = slot_age[s];
    for (int i = 0; i < NSLOT; i++)
      if (slot_used[i] && i != s && slot_age[i] < r) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  // Apply one operation to the private cache and return what the block owes.
  function automatic cache_resp_t cache_apply(cache_op_t op);
    cache_resp_t r;
    int s, lim, fill, victim, slot, vr;
    r = '0;
    lim = (cur_limit > NSLOT) ? NSLOT : cur_limit;
    s = find_slot(op.key);
    r.hit = (s >= 0);
    if (op.cmd == CMD_GET) begin
      if (s >= 0) begin
        if (slot_uses[s] < CNT_MAX) slot_uses[s]++;
        make_newest(s);
        r.read_value = slot_data[s];
      end
    end else if (lim != 0) begin
      if (s >= 0) begin
        if (slot_uses[s] < CNT_MAX) slot_uses[s]++;
        make_newest(s);
        slot_data[s] = op.value;
      end else begin
        fill = 0;
        slot = -1;
        for (int i = 0; i < NSLOT; i++) if (slot_used[i]) fill++;
        if (fill >= lim) begin
          // Lowest use count wins; among equals the oldest touch.
          victim = -1;
          for (int i = 0; i < NSLOT; i++) begin
            if (!slot_used[i]) continue;
            if (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim]))
              victim = i;
          end
          vr = slot_age[victim];
          slot_used[victim] = 1'b0;
          for (int i = 0; i < NSLOT; i++)
            if (slot_used[i] && slot_age[i] > vr) slot_age[i]--;
          r.evicted = 1'b1;
          slot = victim;
        end else begin
          for (int i = 0; i < NSLOT; i++)
            if (!slot_used[i]) begin
              slot = i;
              break;
            end
        end
        for (int i = 0; i < NSLOT; i++) if (slot_used[i]) slot_age[i]++;
        slot_used[slot] = 1'b1;
        slot_key[slot]  = op.key;
        slot_data[slot] = op.value;
        slot_uses[slot] = 1;
        slot_age[slot]  = 0;
      end
    end
    return r;
  endfunction

  // Send one operation; the expectation is queued at the accepting edge.
  // Each call first waits for a falling edge after the last valid drop.
  task automatic send_op(cache_op_t op);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op.cmd;
    in_tdata  <= {op.value, op.key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    resp_fifo.push_back(cache_apply(op));
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Same as send_op, but the predictor's expectation is also compared with a typed-in value.
  task automatic send_op_known(cache_op_t op, cache_resp_t want);
    cache_resp_t got;
    send_op(op);
    got = resp_fifo[$];
    if (got !== want) begin
      n_fail++;
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("directed row key %h: expected %h, predictor gave %h",
                 op.key, want, got);
    end
  endtask

  // Let the block drain fully before a limit write.
  task automatic wait_idle();
    while (resp_fifo.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_limit(int lim);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= lim[CFG_WIDTH-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_limit = lim;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stall, compare at the accepting rising edge.
  always @(posedge clk) begin
    cache_resp_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit        = out_tdata[0];
      got.read_value = out_tdata[32:1];
      got.evicted    = out_tdata[33];
      if (resp_fifo.size() == 0) begin
        n_fail++;
        n_mismatch++;
        if (n_mismatch <= 10) $display("result with nothing expected: %h", out_tdata);
      end else begin
        want = resp_fifo.pop_front();
        if (got.hit !== want.hit || got.read_value !== want.read_value ||
            got.evicted !== want.evicted || out_tdata[39:34] !== '0) begin
          n_fail++;
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected hit %b value %h evicted %b, got hit %b value %h evicted %b",
                     want.hit, want.read_value, want.evicted,
                     got.hit, got.read_value, got.evicted);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: cycles in which no item moves on either stream.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      wdog <= 0;
    else if (in_tvalid || resp_fifo.size() != 0) begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("lfu_cache_lru_tiebreak_tb: FAIL");
        $finish;
      end
    end
  end

  // Key pools: a small pool gives many hits and real eviction contention.
  function automatic logic [31:0] pick_key();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 32'hA500_0000 + $urandom_range(23);
    if (p < 80) return (p & 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
    return $urandom;
  endfunction

  // Directed table: cmd, key, value, expected (only where obvious).
  typedef struct {
    cache_op_t   op;
    logic        known;
    cache_resp_t want;
  } dir_row_t;

  dir_row_t dir_tab[$];

  initial begin
    cache_op_t op;
    int        phase_lims[6];
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = CMD_GET;
    out_tready = 1'b0;
    cfg_valid = 1'b0; cfg_data = '0;
    n_fail = 0; n_mismatch = 0; wdog = 0;
    send_idle_pct = 14; recv_idle_pct = 56;
    for (int i = 0; i < NSLOT; i++) begin
      slot_used[i] = 1'b0; slot_key[i] = '0; slot_data[i] = '0;
      slot_uses[i] = 0; slot_age[i] = 0;
    end
    cur_limit = CFG_RESET;

    // After reset: every get misses and puts of fresh keys do not evict.
    dir_tab.push_back('{'{CMD_GET, 32'h0000_0000, 32'h0}, 1'b1, '{1'b0, 32'h0, 1'b0}});
    dir_tab.push_back('{'{CMD_GET, 32'hFFFF_FFFF, 32'h0}, 1'b1, '{1'b0, 32'h0, 1'b0}});
    dir_tab.push_back('{'{CMD_PUT, 32'hFFFF_FFFF, 32'h8000_0000}, 1'b1, '{1'b0, 32'h0, 1'b0}});
    dir_tab.push_back('{'{CMD_PUT, 32'h0000_0000, 32'h7FFF_FFFF}, 1'b1, '{1'b0, 32'h0, 1'b0}});
    // The all-ones key is an ordinary key, not a miss marker.
    dir_tab.push_back('{'{CMD_GET, 32'hFFFF_FFFF, 32'h0}, 1'b1,
                        '{1'b1, 32'h8000_0000, 1'b0}});
    dir_tab.push_back('{'{CMD_GET, 32'h0000_0000, 32'h0}, 1'b1,
                        '{1'b1, 32'h7FFF_FFFF, 1'b0}});
    dir_tab.push_back('{'{CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1, '{1'b1, 32'h0, 1'b0}});
    dir_tab.push_back('{'{CMD_GET, 32'h0000_0000, 32'h1234}, 1'b1,
                        '{1'b1, 32'hFFFF_FFFF, 1'b0}});
    // Fill the rest; the last of these puts finds the cache full and evicts.
    for (int i = 0; i < 15; i++)
      dir_tab.push_back('{'{CMD_PUT, 32'h5A00_0000 + i, 32'h100 + i}, 1'b0, '0});

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].known) send_op_known(dir_tab[i].op, dir_tab[i].want);
      else send_op(dir_tab[i].op);
    end

    // Limit zero: puts change nothing, gets still see stored entries.
    write_limit(0);
    send_op('{CMD_PUT, 32'hDEAD_BEEF, 32'h1});
    send_op('{CMD_GET, 32'hDEAD_BEEF, 32'h0});
    send_op('{CMD_GET, 32'hFFFF_FFFF, 32'h0});
    // Limit lowered below the fill: one eviction per insert.
    write_limit(3);
    send_op('{CMD_PUT, 32'hDEAD_BEEF, 32'h2});
    send_op('{CMD_PUT, 32'hC0DE_0001, 32'h3});

    // Random phases with several limits, extremes among them.
    phase_lims = '{16, 31, 1, 5, 0, 16};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle_pct = 56; recv_idle_pct = 14; end
      if (ph == 4) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      write_limit(phase_lims[ph]);
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        op.cmd   = 1'($urandom_range(1));
        op.key   = pick_key();
        op.value = $urandom;
        send_op(op);
      end
    end

    wait_idle();
    if (n_fail == 0) $display("lfu_cache_lru_tiebreak_tb: PASS");
    else $display("lfu_cache_lru_tiebreak_tb: FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/lfu_pkg.sv
src/lfu_ctrl.sv
src/lfu_dp.sv
src/lfu_cache_lru_tiebreak.sv
test/lfu_cache_lru_tiebreak_tb.sv
